// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Holds the data widths, operation and status codes and the record that
// travels down the division cell chain.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PROD_W    = 2 * DATA_WIDTH;     // exact product / magnitude width
    localparam int VAL_W     = 2 * DATA_WIDTH + 1; // signed sum of two products
    localparam int SUM_W     = DATA_WIDTH + 1;     // signed sum of two operands
    localparam int SHIFT_HI  = DATA_WIDTH - FRAC_BITS;
    localparam int NUM_CELLS = DATA_WIDTH;         // one quotient bit per cell

    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [PROD_W-1:0]     NEG_LIM = PROD_W'(1) << (DATA_WIDTH - 1);
    localparam logic [PROD_W-1:0]     POS_LIM = NEG_LIM - PROD_W'(1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_OVF     = 2'd2
    } t_status;

    // One result part in sign-magnitude form. For a division, rem is the
    // partial remainder and sh shifts out dividend bits while quotient bits
    // shift in. For the other operations rem already holds the magnitude.
    typedef struct packed {
        logic                  neg;
        logic                  ovf;
        logic [PROD_W-1:0]     rem;
        logic [DATA_WIDTH-1:0] sh;
    } t_part;

    typedef struct packed {
        t_op               op;
        logic              divzero;
        logic [PROD_W-1:0] den;
        t_part             re;
        t_part             im;
    } t_ctx;

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: multiply, combine and prepare stages
// Three pipeline stages: exact partial products and operand sums or differences,
// their combinations and the divisor, then sign-magnitude conversion and the
// division start values.
module cau_front
    import cau_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_ctx                         o_ctx
);

    logic rdy1, rdy2, rdy3;
    logic r_v1, r_v2, r_v3;

    // Stage 1 payload.
    t_op                     r_op1;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_br2, r_p_bi2;
    logic signed [SUM_W-1:0]  r_s_re, r_s_im;
    logic signed [PROD_W-1:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir, n_p_br2, n_p_bi2;
    logic signed [SUM_W-1:0]  n_s_re, n_s_im;

    // Stage 2 payload.
    t_op                     r_op2;
    logic signed [VAL_W-1:0] r_v_re, r_v_im;
    logic [PROD_W-1:0]       r_den;
    logic signed [VAL_W-1:0] n_v_re, n_v_im;
    logic [PROD_W-1:0]       n_den;

    // Stage 3 payload.
    t_ctx r_ctx, n_ctx;

    function automatic t_part prep_part(input t_op op, input logic [VAL_W-1:0] v,
                                        input logic [PROD_W-1:0] den);
        logic [VAL_W-1:0]             absv;
        logic [PROD_W-1:0]            mag;
        logic [PROD_W+FRAC_BITS-1:0]  wide;
        t_part                        p;
        absv  = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
        mag   = absv[PROD_W-1:0];
        wide  = {{FRAC_BITS{1'b0}}, mag} << FRAC_BITS;
        p.neg = v[VAL_W-1];
        p.ovf = 1'b0;
        p.sh  = '0;
        p.rem = mag;
        case (op)
            OP_MUL: p.rem = mag >> FRAC_BITS;
            OP_DIV: begin
                // The quotient reaches 2^DATA_WIDTH exactly when the upper
                // dividend bits already reach the divisor.
                p.rem = mag >> SHIFT_HI;
                p.sh  = wide[DATA_WIDTH-1:0];
                p.ovf = (mag >> SHIFT_HI) >= den;
            end
            default: p.rem = mag;
        endcase
        return p;
    endfunction

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_ctx   = r_ctx;

    always_comb begin
        n_p_rr  = PROD_W'(i_a_re) * PROD_W'(i_b_re);
        n_p_ii  = PROD_W'(i_a_im) * PROD_W'(i_b_im);
        n_p_ri  = PROD_W'(i_a_re) * PROD_W'(i_b_im);
        n_p_ir  = PROD_W'(i_a_im) * PROD_W'(i_b_re);
        n_p_br2 = PROD_W'(i_b_re) * PROD_W'(i_b_re);
        n_p_bi2 = PROD_W'(i_b_im) * PROD_W'(i_b_im);
        if (t_op'(i_op) == OP_SUB) begin
            n_s_re = SUM_W'(i_a_re) - SUM_W'(i_b_re);
            n_s_im = SUM_W'(i_a_im) - SUM_W'(i_b_im);
        end else begin
            n_s_re = SUM_W'(i_a_re) + SUM_W'(i_b_re);
            n_s_im = SUM_W'(i_a_im) + SUM_W'(i_b_im);
        end
    end

    always_comb begin
        n_den = $unsigned(r_p_br2) + $unsigned(r_p_bi2);
        case (r_op1)
            OP_MUL: begin
                n_v_re = VAL_W'(r_p_rr) - VAL_W'(r_p_ii);
                n_v_im = VAL_W'(r_p_ri) + VAL_W'(r_p_ir);
            end
            OP_DIV: begin
                n_v_re = VAL_W'(r_p_rr) + VAL_W'(r_p_ii);
                n_v_im = VAL_W'(r_p_ir) - VAL_W'(r_p_ri);
            end
            default: begin
                n_v_re = VAL_W'(r_s_re);
                n_v_im = VAL_W'(r_s_im);
            end
        endcase
    end

    always_comb begin
        n_ctx.op      = r_op2;
        n_ctx.den     = r_den;
        n_ctx.divzero = (r_op2 == OP_DIV) && (r_den == '0);
        n_ctx.re      = prep_part(r_op2, r_v_re, r_den);
        n_ctx.im      = prep_part(r_op2, r_v_im, r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_op1   <= t_op'(i_op);
            r_p_rr  <= n_p_rr;
            r_p_ii  <= n_p_ii;
            r_p_ri  <= n_p_ri;
            r_p_ir  <= n_p_ir;
            r_p_br2 <= n_p_br2;
            r_p_bi2 <= n_p_bi2;
            r_s_re  <= n_s_re;
            r_s_im  <= n_s_im;
        end
        if (r_v1 && rdy2) begin
            r_op2  <= r_op1;
            r_v_re <= n_v_re;
            r_v_im <= n_v_im;
            r_den  <= n_den;
        end
        if (r_v2 && rdy3) begin
            r_ctx <= n_ctx;
        end
    end

endmodule

// ===== rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring division step
// Produces one quotient bit for the real and the imaginary part and hands the
// record to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell
    import cau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_ctx i_ctx,
    output logic o_valid,
    input  logic i_ready,
    output t_ctx o_ctx
);

    logic r_valid;
    logic rdy;
    t_ctx r_ctx, n_ctx;

    function automatic t_part step(input t_part p, input logic [PROD_W-1:0] den,
                                   input logic active);
        logic [PROD_W:0] r2;
        logic [PROD_W:0] diff;
        logic            take;
        t_part           q;
        r2    = {p.rem, p.sh[DATA_WIDTH-1]};
        diff  = r2 - {1'b0, den};
        take  = r2 >= {1'b0, den};
        q     = p;
        if (active) begin
            q.rem = take ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
            q.sh  = {p.sh[DATA_WIDTH-2:0], take};
        end
        return q;
    endfunction

    assign rdy     = !r_valid || i_ready;
    assign o_ready = rdy;
    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;

    always_comb begin
        n_ctx    = i_ctx;
        n_ctx.re = step(i_ctx.re, i_ctx.den,
                        (i_ctx.op == OP_DIV) && !i_ctx.divzero && !i_ctx.re.ovf);
        n_ctx.im = step(i_ctx.im, i_ctx.den,
                        (i_ctx.op == OP_DIV) && !i_ctx.divzero && !i_ctx.im.ovf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy) begin
            r_ctx <= n_ctx;
        end
    end

endmodule

// ===== rtl/cau_out.sv =====
// ----------------------------------------------------------------------------
// cau_out: saturation and output register
// Clamps each part to the signed data range and forms the status code.
// ----------------------------------------------------------------------------
module cau_out
    import cau_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  t_ctx                         i_ctx,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [1:0]                   o_status
);

    logic                  r_valid;
    logic                  rdy;
    logic [DATA_WIDTH-1:0] r_re, r_im, n_re, n_im;
    t_status               r_status, n_status;
    logic [DATA_WIDTH:0]   sat_re, sat_im;

    // Returns {clamped, value}.
    function automatic logic [DATA_WIDTH:0] saturate(input t_part p, input t_op op);
        logic [PROD_W-1:0]     mag;
        logic [PROD_W-1:0]     neg_mag;
        logic [DATA_WIDTH-1:0] v;
        logic                  o;
        if (op == OP_DIV) begin
            mag = p.ovf ? {PROD_W{1'b1}} : PROD_W'(p.sh);
        end else begin
            mag = p.rem;
        end
        neg_mag = ~mag + PROD_W'(1);
        o       = 1'b0;
        if (p.neg) begin
            if (mag > NEG_LIM) begin
                v = MIN_VAL;
                o = 1'b1;
            end else begin
                v = neg_mag[DATA_WIDTH-1:0];
            end
        end else if (mag > POS_LIM) begin
            v = MAX_VAL;
            o = 1'b1;
        end else begin
            v = mag[DATA_WIDTH-1:0];
        end
        return {o, v};
    endfunction

    assign rdy      = !r_valid || i_ready;
    assign o_ready  = rdy;
    assign o_valid  = r_valid;
    assign o_res_re = r_re;
    assign o_res_im = r_im;
    assign o_status = r_status;

    always_comb begin
        sat_re = saturate(i_ctx.re, i_ctx.op);
        sat_im = saturate(i_ctx.im, i_ctx.op);
        if (i_ctx.divzero) begin
            n_re     = '0;
            n_im     = '0;
            n_status = ST_DIVZERO;
        end else begin
            n_re     = sat_re[DATA_WIDTH-1:0];
            n_im     = sat_im[DATA_WIDTH-1:0];
            n_status = (sat_re[DATA_WIDTH] || sat_im[DATA_WIDTH]) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy) begin
            r_re     <= n_re;
            r_im     <= n_im;
            r_status <= n_status;
        end
    end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Pipeline: 3 front stages, one division cell per quotient bit (32 cells)
// and the output register. Throughput: one transaction per cycle while
// i_ready is high; every stage stalls on its own.
// Reset: synchronous, active low; clears all valid flags, the payload
// registers are not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide
// Signed fixed-point operands, saturating results with status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [1:0]                   o_status
);

    t_ctx chain_ctx   [NUM_CELLS+1];
    logic chain_valid [NUM_CELLS+1];
    logic chain_ready [NUM_CELLS+1];

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_ctx   (chain_ctx[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_ctx   (chain_ctx[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_ctx   (chain_ctx[k+1])
        );
    end

    cau_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[NUM_CELLS]),
        .o_ready  (chain_ready[NUM_CELLS]),
        .i_ctx    (chain_ctx[NUM_CELLS]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

endmodule

// ===== rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker: port-level assertions for the complex arithmetic unit
// Watches both channels and the result codes over time.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [1:0]                   i_op,
    input logic signed [DATA_WIDTH-1:0] i_a_re,
    input logic signed [DATA_WIDTH-1:0] i_a_im,
    input logic signed [DATA_WIDTH-1:0] i_b_re,
    input logic signed [DATA_WIDTH-1:0] i_b_im,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [DATA_WIDTH-1:0] o_res_re,
    input logic signed [DATA_WIDTH-1:0] o_res_im,
    input logic [1:0]                   o_status
);

    // The pipeline holds nothing after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A stalled input transaction stays put until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_op) && $stable(i_a_re)
                                && $stable(i_a_im) && $stable(i_b_re) && $stable(i_b_im))
        else $error("stalled input changed");

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_re) && $stable(o_res_im)
                                && $stable(o_status))
        else $error("stalled result changed");

    // A zero divisor yields a zero result.
    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIVZERO |-> o_res_re == '0 && o_res_im == '0)
        else $error("divide by zero with nonzero result");

    // An overflow flag means at least one part sits on a bound.
    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OVF |->
            o_res_re == MAX_VAL || o_res_re == MIN_VAL ||
            o_res_im == MAX_VAL || o_res_im == MIN_VAL)
        else $error("overflow flagged without a clamped part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
